// ===== hdl/nec_tx_pkg.sv =====
package nec_tx_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 14;

  localparam logic [CFG_INDEX_W-1:0] REG_CARRIER_HALF  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEADER_MARK   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEADER_SPACE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_MARK      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_SPACE    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_SPACE     = 3'd5;

  localparam logic [4:0]  CARRIER_HALF_RST = 5'd13;
  localparam logic [9:0]  LEADER_MARK_RST  = 10'd346;
  localparam logic [13:0] LEADER_SPACE_RST = 14'd4500;
  localparam logic [7:0]  BIT_MARK_RST     = 8'd21;
  localparam logic [11:0] ZERO_SPACE_RST   = 12'd562;
  localparam logic [12:0] ONE_SPACE_RST    = 13'd1686;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_MARK  = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_STOP_MARK  = 3'd5
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] code;
  } in_word_t;

  typedef struct packed {
    logic led;
    logic busy_res;
    logic rejected;
  } out_word_t;

endpackage

// ===== hdl/nec_ir_frame_transmitter.sv =====
// each accepted input word's result word is registered in the output stage
// throughput: one input word per cycle, every cycle, as long as results are taken
// a two-entry output stage (output register plus skid) keeps input ready while
// a result waits; input stalls only when both entries are full
// reset (rst, synchronous): idle, counters cleared, timing registers to defaults
module nec_ir_frame_transmitter #(
  parameter int unsigned CODE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  nec_tx_pkg::in_word_t                  in_word,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output nec_tx_pkg::out_word_t                 out_word,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [nec_tx_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [nec_tx_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned BL_W = $clog2(CODE_BITS + 1);

  logic [4:0]  carrier_half_us;
  logic [9:0]  leader_mark_periods;
  logic [13:0] leader_space_us;
  logic [7:0]  bit_mark_periods;
  logic [11:0] zero_space_us;
  logic [12:0] one_space_us;

  nec_tx_pkg::phase_t   phase, phase_next;
  logic [CODE_BITS-1:0] shift_word, shift_word_next;
  logic [BL_W-1:0]      bits_left, bits_left_next;
  logic [4:0]           half_counter, half_counter_next;
  logic [9:0]           period_counter, period_counter_next;
  logic [13:0]          space_counter, space_counter_next;
  logic                 carrier_level, carrier_level_next;

  logic                  accept;
  nec_tx_pkg::out_word_t res;
  logic                  skid_valid;
  nec_tx_pkg::out_word_t skid_word;
  logic                  out_free;

  logic [CODE_BITS+31:0] code_ext;
  logic [4:0]            hc_inc;
  logic [9:0]            pc_inc;
  logic [13:0]           sc_inc;
  logic                  half_done;
  logic [9:0]            mark_len;
  logic [13:0]           space_len;
  logic                  mark_done;
  logic                  space_done;
  logic [BL_W-1:0]       bits_dec;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !skid_valid;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_half_us     <= nec_tx_pkg::CARRIER_HALF_RST;
      leader_mark_periods <= nec_tx_pkg::LEADER_MARK_RST;
      leader_space_us     <= nec_tx_pkg::LEADER_SPACE_RST;
      bit_mark_periods    <= nec_tx_pkg::BIT_MARK_RST;
      zero_space_us       <= nec_tx_pkg::ZERO_SPACE_RST;
      one_space_us        <= nec_tx_pkg::ONE_SPACE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nec_tx_pkg::REG_CARRIER_HALF: carrier_half_us     <= cfg_data[4:0];
        nec_tx_pkg::REG_LEADER_MARK:  leader_mark_periods <= cfg_data[9:0];
        nec_tx_pkg::REG_LEADER_SPACE: leader_space_us     <= cfg_data[13:0];
        nec_tx_pkg::REG_BIT_MARK:     bit_mark_periods    <= cfg_data[7:0];
        nec_tx_pkg::REG_ZERO_SPACE:   zero_space_us       <= cfg_data[11:0];
        nec_tx_pkg::REG_ONE_SPACE:    one_space_us        <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // carrier and space timing
  assign code_ext  = {{CODE_BITS{1'b0}}, in_word.code};
  assign hc_inc    = half_counter + 5'd1;
  assign pc_inc    = period_counter + 10'd1;
  assign sc_inc    = space_counter + 14'd1;
  assign half_done = !((hc_inc < carrier_half_us) && (hc_inc != 5'd0));
  assign mark_len  = (phase == nec_tx_pkg::PH_LEAD_MARK) ? leader_mark_periods
                                                         : {2'b00, bit_mark_periods};
  assign mark_done = half_done && !carrier_level
                     && ((pc_inc >= mark_len) || (pc_inc == 10'd0));
  always_comb begin
    case (phase)
      nec_tx_pkg::PH_LEAD_SPACE: space_len = leader_space_us;
      nec_tx_pkg::PH_BIT_SPACE:  space_len = shift_word[CODE_BITS-1] ? {1'b0, one_space_us}
                                                                     : {2'b00, zero_space_us};
      default:                   space_len = leader_space_us;
    endcase
  end
  assign space_done = (sc_inc >= space_len) || (sc_inc == 14'd0);
  assign bits_dec   = (bits_left != '0) ? bits_left - BL_W'(1) : bits_left;

  // next state
  always_comb begin
    phase_next          = phase;
    shift_word_next     = shift_word;
    bits_left_next      = bits_left;
    half_counter_next   = half_counter;
    period_counter_next = period_counter;
    space_counter_next  = space_counter;
    carrier_level_next  = carrier_level;
    if (in_word.kind == nec_tx_pkg::KIND_START) begin
      if (phase == nec_tx_pkg::PH_IDLE) begin
        shift_word_next     = code_ext[CODE_BITS-1:0];
        bits_left_next      = BL_W'(CODE_BITS);
        phase_next          = nec_tx_pkg::PH_LEAD_MARK;
        half_counter_next   = 5'd0;
        period_counter_next = 10'd0;
        carrier_level_next  = 1'b1;
      end
    end else begin
      case (phase)
        nec_tx_pkg::PH_IDLE: ;
        nec_tx_pkg::PH_LEAD_MARK, nec_tx_pkg::PH_BIT_MARK, nec_tx_pkg::PH_STOP_MARK: begin
          if (!half_done) begin
            half_counter_next = hc_inc;
          end else begin
            half_counter_next = 5'd0;
            if (carrier_level) begin
              carrier_level_next = 1'b0;
            end else begin
              carrier_level_next  = 1'b1;
              period_counter_next = pc_inc;
            end
          end
          if (mark_done) begin
            carrier_level_next = 1'b0;
            if (phase == nec_tx_pkg::PH_STOP_MARK) begin
              phase_next          = nec_tx_pkg::PH_IDLE;
              half_counter_next   = 5'd0;
              period_counter_next = 10'd0;
            end else begin
              space_counter_next = 14'd0;
              phase_next = (phase == nec_tx_pkg::PH_LEAD_MARK) ? nec_tx_pkg::PH_LEAD_SPACE
                                                               : nec_tx_pkg::PH_BIT_SPACE;
            end
          end
        end
        nec_tx_pkg::PH_LEAD_SPACE, nec_tx_pkg::PH_BIT_SPACE: begin
          space_counter_next = sc_inc;
          if (space_done) begin
            half_counter_next   = 5'd0;
            period_counter_next = 10'd0;
            carrier_level_next  = 1'b1;
            if (phase == nec_tx_pkg::PH_LEAD_SPACE) begin
              phase_next = nec_tx_pkg::PH_BIT_MARK;
            end else begin
              shift_word_next = shift_word << 1;
              bits_left_next  = bits_dec;
              phase_next = (bits_dec == '0) ? nec_tx_pkg::PH_STOP_MARK
                                            : nec_tx_pkg::PH_BIT_MARK;
            end
          end
        end
        default: begin
          phase_next         = nec_tx_pkg::PH_IDLE;
          carrier_level_next = 1'b0;
        end
      endcase
    end
  end

  // result word
  always_comb begin
    res.led      = 1'b0;
    res.busy_res = 1'b0;
    res.rejected = 1'b0;
    if (in_word.kind == nec_tx_pkg::KIND_START) begin
      res.busy_res = 1'b1;
      res.rejected = (phase != nec_tx_pkg::PH_IDLE);
    end else if (phase != nec_tx_pkg::PH_IDLE) begin
      res.busy_res = 1'b1;
      case (phase)
        nec_tx_pkg::PH_LEAD_MARK, nec_tx_pkg::PH_LEAD_SPACE, nec_tx_pkg::PH_BIT_MARK,
        nec_tx_pkg::PH_BIT_SPACE, nec_tx_pkg::PH_STOP_MARK: res.led = carrier_level;
        default: res.led = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= nec_tx_pkg::PH_IDLE;
      shift_word     <= '0;
      bits_left      <= '0;
      half_counter   <= 5'd0;
      period_counter <= 10'd0;
      space_counter  <= 14'd0;
      carrier_level  <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      shift_word     <= shift_word_next;
      bits_left      <= bits_left_next;
      half_counter   <= half_counter_next;
      period_counter <= period_counter_next;
      space_counter  <= space_counter_next;
      carrier_level  <= carrier_level_next;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= accept;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
        if (accept) begin
          skid_word <= res;
        end
      end else if (accept) begin
        out_word <= res;
      end
    end else if (accept) begin
      skid_word <= res;
    end
  end

endmodule
